FILE: rtl/urc_pkg.sv
// Shared types and constants of the ultrasonic ranging controller.
`timescale 1ns / 1ps
`default_nettype none

package urc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } t_phase;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_DISTANCE   = 2'd0;
    localparam t_cfg_idx CFG_TRIGGER_PERIOD = 2'd1;

    localparam int DIST_W   = 10;
    localparam int PERIOD_W = 20;
    localparam int CNT_W    = 17;
    typedef logic [DIST_W-1:0] t_cm;

    localparam t_cm                 MAX_CM_RESET = 10'd400;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd50000;

    localparam int LOW_TICKS  = 2;
    localparam int CM_DIVISOR = 58;
    localparam int MIN_CM     = 2;

    // width / 58 as (width * ceil(2^24 / 58)) >> 24, exact for widths below 2^18
    localparam int              WIDTH_W   = CNT_W + 1;
    localparam int              DIV_MUL_W = 19;
    localparam int              DIV_SHIFT = 24;
    localparam logic [DIV_MUL_W-1:0] DIV_MULT = 19'd289263;
    localparam int              RAW_CM_W  = WIDTH_W + DIV_MUL_W - DIV_SHIFT;

    // max_distance_cm * 58 fits in 16 bits
    localparam int LIMIT_W = 16;

    typedef struct packed {
        logic   trig_level;
        t_cm    distance_cm;
        logic   reading_updated;
        logic   timed_out;
        t_phase phase;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/urc_ifs.sv
// Channel interfaces: echo tick input, result output and register write port.
`timescale 1ns / 1ps
`default_nettype none

interface urc_tick_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface urc_res_if import urc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              trig_level;
    logic [DIST_W-1:0] distance_cm;
    logic              reading_updated;
    logic              timed_out;
    logic [1:0]        phase;

    modport source (output valid, output trig_level, output distance_cm,
                    output reading_updated, output timed_out, output phase,
                    input ready);
    modport sink   (input valid, input trig_level, input distance_cm,
                    input reading_updated, input timed_out, input phase,
                    output ready);
endinterface

interface urc_cfg_if import urc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/urc_median.sv
// Median of the first i_count entries of a small window, by rank counting.
`timescale 1ns / 1ps
`default_nettype none

module urc_median import urc_pkg::*; #(
    parameter int WINDOW = 3
) (
    input  t_cm                           i_values [WINDOW],
    input  logic [$clog2(WINDOW+1)-1:0]   i_count,
    output t_cm                           o_median
);

    localparam int NSEL_W = $clog2(WINDOW + 1);

    always_comb begin
        logic [NSEL_W-1:0] rank;
        logic [NSEL_W-1:0] mid;
        t_cm               acc;
        mid = i_count >> 1;
        acc = '0;
        for (int i = 0; i < WINDOW; i++) begin
            rank = '0;
            // ties break on position so ranks form a permutation
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i && NSEL_W'(j) < i_count &&
                    (i_values[j] < i_values[i] ||
                     (i_values[j] == i_values[i] && j < i))) begin
                    rank = rank + 1'b1;
                end
            end
            if (NSEL_W'(i) < i_count && rank == mid) begin
                acc = acc | i_values[i];
            end
        end
        o_median = acc;
    end

endmodule

`default_nettype wire

FILE: rtl/urc_core.sv
// Per-tick sequencer: trigger timing, echo measurement, history and filtering.
`timescale 1ns / 1ps
`default_nettype none

module urc_core import urc_pkg::*; #(
    parameter int HISTORY_DEPTH = 5,
    parameter int MEDIAN_WINDOW = 3,
    parameter int PULSE_TICKS   = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    urc_tick_if.sink   i_tick,
    urc_cfg_if.sink    i_cfg,
    input  logic       i_room,
    output t_result    o_res,
    output logic       o_res_valid
);

    localparam int PULSE_END = LOW_TICKS + PULSE_TICKS;
    localparam int PULSE_W   = $clog2(PULSE_END + 1);
    localparam int COUNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int NSEL_W    = $clog2(MEDIAN_WINDOW + 1);
    localparam int TAPS      = (MEDIAN_WINDOW > 1) ? MEDIAN_WINDOW - 1 : 1;

    t_cm                 r_max_cm;
    logic [PERIOD_W-1:0] r_period;
    t_phase              r_phase;
    logic [PULSE_W-1:0]  r_pulse;
    logic [PERIOD_W-1:0] r_period_cnt;
    logic [CNT_W-1:0]    r_since;
    logic [CNT_W-1:0]    r_echo;
    t_cm                 r_hist [TAPS];
    logic [COUNT_W-1:0]  r_count;
    t_cm                 r_last;

    t_phase              n_phase;
    logic [PULSE_W-1:0]  n_pulse;
    logic [PERIOD_W-1:0] n_period_cnt;
    logic [CNT_W-1:0]    n_since;
    logic [CNT_W-1:0]    n_echo;
    logic [COUNT_W-1:0]  n_count;
    t_cm                 n_last;

    logic                accept;
    logic                echo;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W:0]   next_cnt;
    logic                offer;
    logic                start;
    t_phase              ph_act;
    logic [PULSE_W-1:0]  pulse_base;
    logic [PULSE_W-1:0]  pulse_inc;
    logic                pulse_done;
    logic [CNT_W-1:0]    since_inc;
    logic [CNT_W-1:0]    echo_inc;
    logic [WIDTH_W-1:0]  width;
    logic [WIDTH_W+DIV_MUL_W-1:0] product;
    logic [RAW_CM_W-1:0] raw_cm;
    logic                cm_ok;
    logic [LIMIT_W-1:0]  limit;
    logic                busy_after;
    logic                tout;
    logic                finish;
    logic                updated;
    logic                trig;
    logic [NSEL_W-1:0]   n_sel;
    t_cm                 win [MEDIAN_WINDOW];
    t_cm                 median;

    assign accept       = i_tick.valid && i_room;
    assign i_tick.ready = i_room;
    assign i_cfg.ready  = 1'b1;
    assign echo         = i_tick.echo_level;

    // period counter runs first; an idle block takes the offer on this tick
    assign period_eff   = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign next_cnt     = {1'b0, r_period_cnt} + 1'b1;
    assign offer        = next_cnt >= {1'b0, period_eff};
    assign n_period_cnt = offer ? '0 : next_cnt[PERIOD_W-1:0];
    assign start        = offer && (r_phase == PH_IDLE);
    assign ph_act       = start ? PH_TRIG : r_phase;

    assign pulse_base = start ? '0 : r_pulse;
    assign pulse_inc  = pulse_base + 1'b1;
    assign pulse_done = pulse_inc >= PULSE_W'(PULSE_END);

    assign since_inc = (&r_since) ? r_since : r_since + 1'b1;
    assign echo_inc  = (&r_echo) ? r_echo : r_echo + 1'b1;

    assign width   = {1'b0, r_echo} + 1'b1;
    assign product = width * DIV_MULT;
    assign raw_cm  = product[DIV_SHIFT +: RAW_CM_W];
    assign cm_ok   = (raw_cm >= RAW_CM_W'(MIN_CM)) && (raw_cm <= RAW_CM_W'(r_max_cm));

    assign limit      = LIMIT_W'(r_max_cm) * LIMIT_W'(CM_DIVISOR);
    assign busy_after = (ph_act == PH_WAIT) || (ph_act == PH_MEAS && echo);
    assign tout       = busy_after && (since_inc > CNT_W'(limit));
    assign finish     = (ph_act == PH_MEAS) && !echo;
    assign updated    = finish && cm_ok;

    assign n_count = (int'(r_count) < HISTORY_DEPTH) ? r_count + 1'b1 : r_count;
    assign n_sel   = (int'(n_count) < MEDIAN_WINDOW) ? NSEL_W'(n_count)
                                                     : NSEL_W'(MEDIAN_WINDOW);

    // newest reading first, then the stored history taps
    always_comb begin
        win[0] = raw_cm[DIST_W-1:0];
        for (int k = 1; k < MEDIAN_WINDOW; k++) begin
            win[k] = r_hist[k-1];
        end
    end

    urc_median #(
        .WINDOW (MEDIAN_WINDOW)
    ) u_median (
        .i_values (win),
        .i_count  (n_sel),
        .o_median (median)
    );

    always_comb begin
        n_phase = ph_act;
        unique case (ph_act)
            PH_IDLE: n_phase = PH_IDLE;
            PH_TRIG: begin
                if (pulse_done) n_phase = PH_WAIT;
            end
            PH_WAIT: begin
                if (tout) n_phase = PH_IDLE;
                else if (echo) n_phase = PH_MEAS;
            end
            PH_MEAS: begin
                if (tout || !echo) n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        trig    = 1'b0;
        n_pulse = r_pulse;
        n_since = r_since;
        n_echo  = r_echo;
        unique case (ph_act)
            PH_IDLE: ;
            PH_TRIG: begin
                trig    = pulse_base >= PULSE_W'(LOW_TICKS);
                n_pulse = pulse_done ? '0 : pulse_inc;
                if (pulse_done) n_since = '0;
            end
            PH_WAIT: begin
                n_since = since_inc;
                if (echo) n_echo = '0;
            end
            PH_MEAS: begin
                n_since = since_inc;
                if (echo) n_echo = echo_inc;
            end
        endcase
        if (tout) n_last = '0;
        else if (updated) n_last = median;
        else n_last = r_last;
    end

    assign o_res.trig_level      = trig;
    assign o_res.distance_cm     = n_last;
    assign o_res.reading_updated = updated;
    assign o_res.timed_out       = tout;
    assign o_res.phase           = n_phase;
    assign o_res_valid           = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cm     <= MAX_CM_RESET;
            r_period     <= PERIOD_RESET;
            r_phase      <= PH_IDLE;
            r_pulse      <= '0;
            r_period_cnt <= '0;
            r_since      <= '0;
            r_echo       <= '0;
            r_count      <= '0;
            r_last       <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MAX_DISTANCE:   r_max_cm <= i_cfg.data[DIST_W-1:0];
                    CFG_TRIGGER_PERIOD: r_period <= i_cfg.data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_pulse      <= n_pulse;
                r_period_cnt <= n_period_cnt;
                r_since      <= n_since;
                r_echo       <= n_echo;
                r_last       <= n_last;
                if (updated) r_count <= n_count;
            end
        end
    end

    // history shifts newest-first; entries are only read once written
    always_ff @(posedge i_clk) begin
        if (accept && updated) begin
            r_hist[0] <= raw_cm[DIST_W-1:0];
            for (int k = 1; k < TAPS; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/urc_skid.sv
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module urc_skid import urc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_data,
    input  logic    i_valid,
    output logic    o_ready,
    output t_result o_data,
    output logic    o_valid,
    input  logic    i_ready
);

    t_result r_main;
    t_result r_skid;
    logic    r_main_valid;
    logic    r_skid_valid;
    logic    push;
    logic    pop;

    assign o_ready = !r_skid_valid;
    assign o_data  = r_main;
    assign o_valid = r_main_valid;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_main_valid && !pop) r_skid_valid <= 1'b1;
            else r_main_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // payload: promote the skid entry on drain, else load the incoming transaction
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) r_main <= r_skid;
        end else if (push) begin
            if (r_main_valid && !pop) r_skid <= i_data;
            else r_main <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_ranging_controller.sv
// Ultrasonic ranging controller: trigger sequencing, echo timing, median filter.
//
// Usage:
//   i_tick carries one transaction per microsecond with the sampled echo level.
//   Every accepted tick yields exactly one result transaction on o_res: trigger
//   pin level, filtered distance in cm, reading/timeout flags and the phase.
//   i_cfg writes max_distance_cm (index 0) and trigger_period_us (index 1);
//   other indexes are ignored. Write only while no result is outstanding.
// Timing:
//   The result of an accepted tick is written into the output buffer at the
//   next clock edge. Throughput is one tick per cycle while the buffer has
//   room; period counter, divide by 58 and median window are combinational.
// Reset:
//   Synchronous, active low. Registers return to 400 cm and 50000 us, the
//   sequencer goes idle, the history counts as empty and no result is valid.
// Back-pressure:
//   A two-entry output buffer holds results while o_res.ready is low; the
//   tick channel stays ready until both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_ranging_controller import urc_pkg::*; #(
    parameter int HISTORY_DEPTH = 5,
    parameter int MEDIAN_WINDOW = 3,
    parameter int PULSE_TICKS   = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    urc_tick_if.sink   i_tick,
    urc_cfg_if.sink    i_cfg,
    urc_res_if.source  o_res
);

    t_result core_res;
    logic    core_valid;
    logic    buf_room;
    t_result out_res;

    urc_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MEDIAN_WINDOW (MEDIAN_WINDOW),
        .PULSE_TICKS   (PULSE_TICKS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick),
        .i_cfg       (i_cfg),
        .i_room      (buf_room),
        .o_res       (core_res),
        .o_res_valid (core_valid)
    );

    urc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (core_res),
        .i_valid (core_valid),
        .o_ready (buf_room),
        .o_data  (out_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready)
    );

    assign o_res.trig_level      = out_res.trig_level;
    assign o_res.distance_cm     = out_res.distance_cm;
    assign o_res.reading_updated = out_res.reading_updated;
    assign o_res.timed_out       = out_res.timed_out;
    assign o_res.phase           = out_res.phase;

endmodule

`default_nettype wire

FILE: rtl/urc_checker.sv
// Port-level checks for the ranging controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module urc_checker import urc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_trig,
    input logic [DIST_W-1:0] i_dist,
    input logic              i_updated,
    input logic              i_tout,
    input logic [1:0]        i_phase
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_trig, i_dist, i_updated, i_tout, i_phase}))
        else $error("result changed while stalled");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tout |-> i_phase == PH_IDLE && i_dist == '0 && !i_updated)
        else $error("timeout without idle phase and cleared distance");

    a_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_updated |-> i_phase == PH_IDLE && i_dist != '0)
        else $error("reading stored without idle phase or with zero distance");

    a_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_trig |-> i_phase == PH_TRIG || i_phase == PH_WAIT)
        else $error("trigger driven outside triggering");

endmodule

bind ultrasonic_ranging_controller urc_checker u_urc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_trig      (o_res.trig_level),
    .i_dist      (o_res.distance_cm),
    .i_updated   (o_res.reading_updated),
    .i_tout      (o_res.timed_out),
    .i_phase     (o_res.phase)
);

`default_nettype wire
